// File: rtl/assert_macros.svh
// Assertion helpers for the charge port monitor.
// Both macros vanish when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Checked on every rising edge outside of reset.
`define CPM_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define CPM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define CPM_ASSERT(lbl, clk, rst_n, prop, msg)
`define CPM_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// File: rtl/cpm_pkg.sv
`timescale 1ns / 1ps

package cpm_pkg;

	// Number of charging ports and the width of an index into the port state.
	localparam int PORTS = 3;
	localparam int PortIdxW = (PORTS > 1) ? $clog2(PORTS) : 1;

	// Field widths.
	localparam int AdcW = 12;
	localparam int CurW = 12;
	localparam int CutTimeW = 16;
	localparam int MaskW = 3;
	localparam int LowW = 16;
	localparam int AccW = 32;
	localparam int MahW = 21;
	localparam int BlinkW = 8;

	// Charge is reported in mAh: accumulated mA-seconds over 3600.
	localparam int SecPerHour = 3600;
	localparam logic [12:0] SEC_PER_HOUR = 13'(SecPerHour);

	// Reciprocal of 100 for narrow currents: x / 100 == (x * 5243) >> 19.
	localparam int Div100Mul = 5243;
	localparam int Div100Shift = 19;

	// Largest current a sample can produce.
	localparam logic [CurW-1:0] MAX_CURRENT = 12'd3327;

	// Configuration reset values.
	localparam logic [CurW-1:0] THRESH_RST = 12'd50;
	localparam logic [CutTimeW-1:0] LOW_LIMIT_RST = 16'd10;
	localparam logic [MaskW-1:0] AUTOOFF_RST = 3'd7;
	localparam logic [MaskW-1:0] LED_MASK_RST = 3'd7;

	// Event kinds.
	typedef enum logic [1:0] {
		OP_SAMPLE = 2'd0,
		OP_SECOND = 2'd1,
		OP_BLINK  = 2'd2,
		OP_START  = 2'd3
	} op_t;

	// Register map, word index.
	typedef enum logic [1:0] {
		REG_THRESH    = 2'd0,
		REG_LOW_LIMIT = 2'd1,
		REG_AUTOOFF   = 2'd2,
		REG_LED_MASK  = 2'd3
	} reg_idx_t;

	// One status result.
	typedef struct packed {
		logic [31:0]     charge_seconds;
		logic [MahW-1:0] charge_mah;
		logic [CurW-1:0] current_ma;
		logic            led_on;
		logic            output_on;
		logic [1:0]      port_out;
	} result_t;

endpackage

// File: rtl/charge_port_monitor_core.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Charge port monitor. Each input beat is one event (sample, one-second tick, blink tick
// or start) for one port, and each produces exactly one status beat for that port, taken
// after the event's update. The block takes one beat per clock cycle unless the status
// receiver stalls: the addressed port's state is read, updated and written back in the
// same cycle that the event moves from the input register to the result register, so
// back-to-back events to the same port need no stall. Charge in mAh is kept as a
// running quotient and remainder of 3600 next to the raw accumulator, so no divider is
// needed. There is no clearing pass: all port state is cleared by reset.
module charge_port_monitor_core (
	input  logic        clk,
	input  logic        arst_n,
	// Input events.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [1:0] port_index, [13:2] adc_sample, [15:14] zero
	input  logic [15:0] s_axis_tdata,
	// [1:0] opcode
	input  logic [1:0]  s_axis_tuser,
	// Status results.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [1:0] port_out, [2] output_on, [3] led_on, [15:4] current_ma,
	// [36:16] charge_mah, [68:37] charge_seconds, [71:69] zero
	output logic [71:0] m_axis_tdata,
	// Configuration.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	import cpm_pkg::*;

	// ------------------------------------------------------------------
	// Configuration registers.
	// ------------------------------------------------------------------
	logic [CurW-1:0]     thresh_ma_q;
	logic [CutTimeW-1:0] low_limit_q;
	logic [MaskW-1:0]    autooff_q;
	logic [MaskW-1:0]    led_mask_q;
	reg_idx_t            reg_idx;
	logic                cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_ma_q <= THRESH_RST;
			low_limit_q <= LOW_LIMIT_RST;
			autooff_q   <= AUTOOFF_RST;
			led_mask_q  <= LED_MASK_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_THRESH:    thresh_ma_q <= pwdata[CurW-1:0];
				REG_LOW_LIMIT: low_limit_q <= pwdata[CutTimeW-1:0];
				REG_AUTOOFF:   autooff_q   <= pwdata[MaskW-1:0];
				REG_LED_MASK:  led_mask_q  <= pwdata[MaskW-1:0];
			endcase
		end
	end

	// Register read back.
	always_comb begin
		unique case (reg_idx)
			REG_THRESH:    prdata = 32'(thresh_ma_q);
			REG_LOW_LIMIT: prdata = 32'(low_limit_q);
			REG_AUTOOFF:   prdata = 32'(autooff_q);
			REG_LED_MASK:  prdata = 32'(led_mask_q);
		endcase
	end

	// ------------------------------------------------------------------
	// Input stage.
	// ------------------------------------------------------------------
	logic            valid_s1;
	op_t             op_s1;
	logic [1:0]      port_s1;
	logic [AdcW-1:0] adc_s1;
	logic            advance;
	logic            valid_s2;
	result_t         res_s2;

	// The input stage moves on whenever the result register is free or being emptied.
	assign advance       = !valid_s2 || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1   <= OP_SAMPLE;
			port_s1 <= '0;
			adc_s1  <= '0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			op_s1   <= op_t'(s_axis_tuser[1:0]);
			port_s1 <= s_axis_tdata[1:0];
			adc_s1  <= s_axis_tdata[13:2];
		end
	end

	// ------------------------------------------------------------------
	// Per-port state.
	// ------------------------------------------------------------------
	logic [CurW-1:0]   cur_q     [PORTS];
	logic [LowW-1:0]   low_q     [PORTS];
	logic              en_q      [PORTS];
	logic [AccW-1:0]   acc_q     [PORTS];
	logic [MahW-1:0]   mah_q     [PORTS];
	logic [11:0]       rem_q     [PORTS];
	logic [31:0]       secs_q    [PORTS];
	logic [BlinkW-1:0] blink_q   [PORTS];
	logic [BlinkW-1:0] pause_q   [PORTS];
	logic              led_q     [PORTS];

	logic [PortIdxW-1:0] idx;
	logic                port_ok;
	logic                upd;
	logic [3:0]          auto_ext;
	logic [3:0]          led_ext;

	assign idx      = PortIdxW'(port_s1);
	assign port_ok  = 32'(port_s1) < PORTS;
	assign upd      = valid_s1 && advance && port_ok;
	// Mask bits beyond the register width read as zero.
	assign auto_ext = 4'(autooff_q);
	assign led_ext  = 4'(led_mask_q);

	// Current state of the addressed port and its next value.
	logic [CurW-1:0]   cur_n;
	logic [LowW-1:0]   low_n;
	logic              en_n;
	logic [AccW-1:0]   acc_n;
	logic [MahW-1:0]   mah_n;
	logic [11:0]       rem_n;
	logic [31:0]       secs_n;
	logic [BlinkW-1:0] blink_n;
	logic [BlinkW-1:0] pause_n;
	logic              led_n;

	logic [15:0]        scaled;
	logic [AccW:0]      acc_sum;
	logic [12:0]        rem_sum;
	logic [24:0]        cur_x100;
	logic [6:0]         cur_hundreds;
	logic [BlinkW-1:0]  blink_inc;
	logic [BlinkW-1:0]  pause_inc;

	// Arithmetic helpers that do not depend on the opcode.
	always_comb begin
		scaled       = 16'(adc_s1) * 16'd13;
		acc_sum      = {1'b0, acc_q[idx]} + (AccW+1)'(cur_q[idx]);
		rem_sum      = 13'(rem_q[idx]) + 13'(cur_q[idx]);
		cur_x100     = 25'(cur_q[idx]) * 25'(Div100Mul);
		cur_hundreds = 7'(cur_x100[24:Div100Shift]);
		blink_inc    = blink_q[idx] + 1'b1;
		pause_inc    = pause_q[idx] + 1'b1;
	end

	// Event update of the addressed port.
	always_comb begin
		cur_n   = cur_q[idx];
		low_n   = low_q[idx];
		en_n    = en_q[idx];
		acc_n   = acc_q[idx];
		mah_n   = mah_q[idx];
		rem_n   = rem_q[idx];
		secs_n  = secs_q[idx];
		blink_n = blink_q[idx];
		pause_n = pause_q[idx];
		led_n   = led_q[idx];
		unique case (op_s1)
			OP_SAMPLE: begin
				cur_n = scaled[15:4];
				if (auto_ext[port_s1]) begin
					if (cur_n < thresh_ma_q) begin
						if (low_n != '1) begin
							low_n = low_n + 1'b1;
						end
						if (low_n > low_limit_q) begin
							en_n = 1'b0;
						end
					end else begin
						low_n = '0;
					end
				end
			end
			OP_SECOND: begin
				if (cur_q[idx] > thresh_ma_q) begin
					acc_n  = acc_sum[AccW-1:0];
					secs_n = secs_q[idx] + 1'b1;
					// On wrap the new total is below one hour's worth of a single step.
					if (acc_sum[AccW]) begin
						mah_n = '0;
						rem_n = acc_sum[11:0];
					end else if (rem_sum >= SEC_PER_HOUR) begin
						mah_n = mah_q[idx] + 1'b1;
						rem_n = 12'(rem_sum - SEC_PER_HOUR);
					end else begin
						rem_n = rem_sum[11:0];
					end
				end
			end
			OP_BLINK: begin
				if (led_ext[port_s1]) begin
					blink_n = blink_inc;
					if (blink_inc[0]) begin
						led_n = 1'b0;
					end else if ({1'b0, blink_inc[BlinkW-1:1]} <= cur_hundreds) begin
						led_n   = 1'b1;
						pause_n = '0;
					end else begin
						pause_n = pause_inc;
						led_n   = 1'b0;
						if (pause_inc >= 8'd2) begin
							blink_n = '0;
						end
					end
				end
			end
			OP_START: begin
				en_n  = 1'b1;
				low_n = '0;
			end
		endcase
	end

	// Write back the addressed port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < PORTS; p++) begin
				cur_q[p]   <= '0;
				low_q[p]   <= '0;
				en_q[p]    <= 1'b0;
				acc_q[p]   <= '0;
				mah_q[p]   <= '0;
				rem_q[p]   <= '0;
				secs_q[p]  <= '0;
				blink_q[p] <= '0;
				pause_q[p] <= '0;
				led_q[p]   <= 1'b0;
			end
		end else if (upd) begin
			cur_q[idx]   <= cur_n;
			low_q[idx]   <= low_n;
			en_q[idx]    <= en_n;
			acc_q[idx]   <= acc_n;
			mah_q[idx]   <= mah_n;
			rem_q[idx]   <= rem_n;
			secs_q[idx]  <= secs_n;
			blink_q[idx] <= blink_n;
			pause_q[idx] <= pause_n;
			led_q[idx]   <= led_n;
		end
	end

	// ------------------------------------------------------------------
	// Result register.
	// ------------------------------------------------------------------
	result_t res_n;

	// A port beyond the last one reports only its index.
	always_comb begin
		res_n          = '0;
		res_n.port_out = port_s1;
		if (port_ok) begin
			res_n.output_on      = en_n;
			res_n.led_on         = led_n;
			res_n.current_ma     = cur_n;
			res_n.charge_mah     = mah_n;
			res_n.charge_seconds = secs_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_s2 <= res_n;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = 72'(res_s2);

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
	`CPM_ASSERT(a_rem_below_hour, clk, arst_n,
		(valid_s1 && port_ok) |-> (rem_q[idx] < SEC_PER_HOUR),
		"charge remainder reached one hour")
	`CPM_ASSERT(a_result_follows, clk, arst_n,
		(valid_s1 && advance) |=> (valid_s2 && res_s2.port_out == $past(port_s1)),
		"result does not follow its input beat")
	`CPM_ASSERT(a_bad_port_zero, clk, arst_n,
		(valid_s2 && 32'(res_s2.port_out) >= PORTS) |-> (res_s2.output_on == 1'b0
		&& res_s2.led_on == 1'b0 && res_s2.current_ma == '0
		&& res_s2.charge_mah == '0 && res_s2.charge_seconds == '0),
		"unknown port reports state")
	`CPM_ASSERT(a_current_range, clk, arst_n,
		valid_s2 |-> (res_s2.current_ma <= MAX_CURRENT),
		"current above sample range")

endmodule

// File: tb/charge_port_monitor_checker.sv
`timescale 1ns / 1ps

// Watches the event, status and register channels of the charge port monitor.
// It keeps its own copy of the per-port state and predicts one status beat for
// every accepted event beat. It then compares each status beat in order.
module charge_port_monitor_checker
	import cpm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,
	input  logic [1:0]  s_axis_tuser,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [71:0] m_axis_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output int          fail_count,
	output int          pending,
	output int          beats_checked,
	output int          cutoffs_seen
);

	// Register copy, starting from the reset values.
	logic [CurW-1:0]     thresh_ma_q = THRESH_RST;
	logic [CutTimeW-1:0] low_limit_q = LOW_LIMIT_RST;
	logic [MaskW-1:0]    autooff_q   = AUTOOFF_RST;
	logic [MaskW-1:0]    led_mask_q  = LED_MASK_RST;

	// Per-port state, all starting from zero.
	logic [CurW-1:0]   cur_ma     [PORTS] = '{default: '0};
	logic [LowW-1:0]   low_cnt    [PORTS] = '{default: '0};
	logic              out_en     [PORTS] = '{default: '0};
	logic [AccW-1:0]   charge_acc [PORTS] = '{default: '0};
	logic [31:0]       secs       [PORTS] = '{default: '0};
	logic [BlinkW-1:0] blink_cnt  [PORTS] = '{default: '0};
	logic [BlinkW-1:0] pause_cnt  [PORTS] = '{default: '0};
	logic              led_lvl    [PORTS] = '{default: '0};

	// Status beats predicted but not yet seen, oldest first.
	result_t status_q[$];

	// Applies one event to the port state and returns the status that follows it.
	function automatic result_t apply_event(op_t op, logic [1:0] port,
			logic [AdcW-1:0] adc);
		result_t r;
		int p;
		r = '0;
		r.port_out = port;
		if (port >= PORTS)
			return r;
		p = port;
		case (op)
			OP_SAMPLE: begin
				cur_ma[p] = CurW'((13 * int'(adc)) / 16);
				if (autooff_q[p]) begin
					if (cur_ma[p] < thresh_ma_q) begin
						if (low_cnt[p] != '1)
							low_cnt[p] = low_cnt[p] + 1'b1;
						if (low_cnt[p] > low_limit_q) begin
							if (out_en[p])
								cutoffs_seen++;
							out_en[p] = 1'b0;
						end
					end else begin
						low_cnt[p] = '0;
					end
				end
			end
			OP_SECOND: begin
				if (cur_ma[p] > thresh_ma_q) begin
					charge_acc[p] = charge_acc[p] + AccW'(cur_ma[p]);
					secs[p] = secs[p] + 1;
				end
			end
			OP_BLINK: begin
				// Blink once per 100 mA, then hold the LED dark for two even ticks.
				if (led_mask_q[p]) begin
					blink_cnt[p] = blink_cnt[p] + 1'b1;
					if (blink_cnt[p][0]) begin
						led_lvl[p] = 1'b0;
					end else if ((blink_cnt[p] >> 1) <= (cur_ma[p] / 100)) begin
						led_lvl[p] = 1'b1;
						pause_cnt[p] = '0;
					end else begin
						pause_cnt[p] = pause_cnt[p] + 1'b1;
						led_lvl[p] = 1'b0;
						if (pause_cnt[p] >= 2)
							blink_cnt[p] = '0;
					end
				end
			end
			OP_START: begin
				out_en[p] = 1'b1;
				low_cnt[p] = '0;
			end
		endcase
		r.output_on = out_en[p];
		r.led_on = led_lvl[p];
		r.current_ma = cur_ma[p];
		r.charge_mah = MahW'(charge_acc[p] / 3600);
		r.charge_seconds = secs[p];
		return r;
	endfunction

	function automatic int field_diff(string field, longint unsigned want,
			longint unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", field, want, got);
			return 1;
		end
		return 0;
	endfunction

	// Register writes, event beats and status beats, sampled at the clock edge.
	always @(posedge clk) begin
		result_t want;
		result_t got;
		int errs;
		if (arst_n) begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[3:2]))
					REG_THRESH:    thresh_ma_q = pwdata[CurW-1:0];
					REG_LOW_LIMIT: low_limit_q = pwdata[CutTimeW-1:0];
					REG_AUTOOFF:   autooff_q = pwdata[MaskW-1:0];
					REG_LED_MASK:  led_mask_q = pwdata[MaskW-1:0];
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				status_q.push_back(apply_event(op_t'(s_axis_tuser), s_axis_tdata[1:0],
						s_axis_tdata[13:2]));
			if (m_axis_tvalid && m_axis_tready) begin
				got = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
				if (status_q.size() == 0) begin
					$error("status beat for port %0d with no event waiting", got.port_out);
					fail_count++;
				end else begin
					want = status_q.pop_front();
					errs = field_diff("port_out", want.port_out, got.port_out)
						+ field_diff("output_on", want.output_on, got.output_on)
						+ field_diff("led_on", want.led_on, got.led_on)
						+ field_diff("current_ma", want.current_ma, got.current_ma)
						+ field_diff("charge_mah", want.charge_mah, got.charge_mah)
						+ field_diff("charge_seconds", want.charge_seconds,
							got.charge_seconds);
					if (errs != 0)
						fail_count++;
					beats_checked++;
				end
			end
			pending = status_q.size();
		end else begin
			// Counters start from zero while the block is held in reset.
			fail_count = 0;
			pending = 0;
			beats_checked = 0;
			cutoffs_seen = 0;
		end
	end

endmodule

// File: tb/tb_charge_port_monitor_core.sv
`timescale 1ns / 1ps

module tb_charge_port_monitor_core;
	import cpm_pkg::*;

	localparam int StallLimit = 1000;
	localparam int DrainCycles = 8;
	localparam int NumPhases = 8;
	localparam int RandPerPhase = 107;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	// [1:0] port_index, [13:2] adc_sample, [15:14] zero
	logic [15:0] s_axis_tdata = '0;
	// [1:0] opcode
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// [1:0] port_out, [2] output_on, [3] led_on, [15:4] current_ma,
	// [36:16] charge_mah, [68:37] charge_seconds, [71:69] zero
	logic [71:0] m_axis_tdata;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	int fail_count;
	int pending;
	int beats_checked;
	int cutoffs_seen;

	// Flow-control mix and stimulus bookkeeping.
	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	int stuck_cycles = 0;
	int events_sent = 0;
	int op_counts[4] = '{default: 0};
	int bad_port_events = 0;
	logic [CurW-1:0] thresh_tb = THRESH_RST;

	charge_port_monitor_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	charge_port_monitor_checker status_checker (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.pready(pready),
		.paddr(paddr),
		.pwdata(pwdata),
		.fail_count(fail_count),
		.pending(pending),
		.beats_checked(beats_checked),
		.cutoffs_seen(cutoffs_seen)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Status receiver stalls at random according to the current mix.
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
	end

	// Watchdog: ends the run when no beat and no register write moves for too long.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (psel && penable && pready)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles == StallLimit) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	// Offers one event beat, with random idle cycles first, and waits until it is taken.
	// The valid stays high afterwards so that back-to-back beats need no gap.
	task automatic send_event(op_t op, logic [1:0] port, logic [AdcW-1:0] adc);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {2'b00, adc, port};
		s_axis_tuser <= op;
		@(negedge clk);
		while (!s_axis_tready)
			@(negedge clk);
		@(posedge clk);
		events_sent++;
		op_counts[op]++;
		if (port >= PORTS)
			bad_port_events++;
	endtask

	// Drops the event valid and waits until every predicted status beat has arrived.
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	// One register write: setup cycle, then access until pready. The bus is left
	// selected so that a following write can go straight to its setup cycle.
	task automatic write_reg(reg_idx_t idx, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		while (!pready)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic set_regs(logic [CurW-1:0] thresh, logic [CutTimeW-1:0] low_limit,
			logic [MaskW-1:0] autooff, logic [MaskW-1:0] led_mask);
		write_reg(REG_THRESH, 32'(thresh));
		write_reg(REG_LOW_LIMIT, 32'(low_limit));
		write_reg(REG_AUTOOFF, 32'(autooff));
		write_reg(REG_LED_MASK, 32'(led_mask));
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		thresh_tb = thresh;
	endtask

	// Register setting of each phase, the extremes among them.
	task automatic configure_phase(int ph);
		case (ph)
			1: set_regs(12'd0, 16'd0, 3'd0, 3'd0);
			2: set_regs(MAX_CURRENT, 16'hFFFF, 3'd7, 3'd7);
			3: set_regs(12'd200, 16'd2, 3'd5, 3'd2);
			4: set_regs(12'($urandom_range(0, 600)), 16'($urandom_range(0, 6)),
					3'($urandom), 3'($urandom));
			5: set_regs(12'd100, 16'd1, 3'd3, 3'd6);
			6: set_regs(12'($urandom_range(0, MAX_CURRENT)), 16'($urandom_range(0, 20)),
					3'($urandom), 3'($urandom));
			default: set_regs(12'd50, 16'd3, 3'd7, 3'd7);
		endcase
	endtask

	// Raw reading for a burst: below, near or above the cut current, or anywhere.
	function automatic logic [AdcW-1:0] pick_adc(int kind);
		int knee;
		int roll;
		knee = (int'(thresh_tb) * 16) / 13;
		if (knee > 4095)
			knee = 4095;
		roll = $urandom_range(0, 9);
		case (kind)
			0: return (roll < 9) ? 12'($urandom_range(0, knee)) : 12'($urandom);
			1: return (roll < 8) ? 12'($urandom_range(knee, 4095))
					: 12'($urandom_range(knee > 2 ? knee - 2 : 0, knee + 2));
			3: return 12'($urandom_range(0, 1000));
			default: begin
				if (roll == 0)
					return '0;
				if (roll == 1)
					return '1;
				if (roll < 4)
					return 12'($urandom_range(knee > 2 ? knee - 2 : 0, knee + 2));
				return 12'($urandom);
			end
		endcase
	endfunction

	// A run of events on one port: a draining session, a charging session, a mix,
	// or a long run of blink ticks. Now and then the port does not exist.
	task automatic run_burst();
		logic [1:0] port;
		int kind;
		int len;
		int roll;
		int k;
		op_t op;
		port = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, PORTS - 1));
		kind = $urandom_range(0, 3);
		len = (kind == 3) ? $urandom_range(10, 40) : $urandom_range(3, 12);
		for (k = 0; k < len; k++) begin
			roll = $urandom_range(0, 99);
			if (kind == 3) begin
				if (k == 0 || roll >= 95)
					op = OP_SAMPLE;
				else
					op = (roll < 90) ? OP_BLINK : OP_SECOND;
			end else if (kind == 2) begin
				op = (roll < 30) ? OP_SAMPLE : (roll < 55) ? OP_SECOND
					: (roll < 85) ? OP_BLINK : OP_START;
			end else if (k == 0 && roll < 50) begin
				op = OP_START;
			end else begin
				op = (roll < 60) ? OP_SAMPLE : (roll < 85) ? OP_SECOND
					: (roll < 95) ? OP_BLINK : OP_START;
			end
			send_event(op, port, pick_adc(kind));
		end
	endtask

	initial begin
		int ph;
		int target;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed events under the reset register values.
		send_event(OP_START, 2'd0, 12'd0);
		send_event(OP_SAMPLE, 2'd0, 12'hFFF);
		send_event(OP_SECOND, 2'd0, 12'd0);
		send_event(OP_BLINK, 2'd0, 12'd0);
		send_event(OP_BLINK, 2'd0, 12'd0);
		// A current equal to the cut current neither counts as low nor as charging.
		send_event(OP_SAMPLE, 2'd0, 12'd62);
		send_event(OP_SECOND, 2'd0, 12'd0);
		send_event(OP_SAMPLE, 2'd0, 12'd63);
		send_event(OP_SECOND, 2'd0, 12'hFFF);
		// Events for a port that does not exist, then a second tick to the last port.
		send_event(OP_SAMPLE, 2'd3, 12'hFFF);
		send_event(OP_START, 2'd3, 12'hAAA);
		send_event(OP_BLINK, 2'd3, 12'h555);
		send_event(OP_SECOND, 2'd2, 12'd0);
		// Eleven low samples after a start cut the output off.
		send_event(OP_START, 2'd1, 12'd0);
		repeat (11) send_event(OP_SAMPLE, 2'd1, 12'd0);

		// Random phases, each with its own register setting and flow-control mix.
		for (ph = 0; ph < NumPhases; ph++) begin
			if (ph != 0) begin
				wait_idle();
				configure_phase(ph);
			end
			case (ph % 4)
				0: begin
					src_idle_pct = 0;
					sink_stall_pct = 0;
				end
				1: begin
					src_idle_pct = 47;
					sink_stall_pct = 0;
				end
				2: begin
					src_idle_pct = 0;
					sink_stall_pct = 47;
				end
				default: begin
					src_idle_pct = 26;
					sink_stall_pct = 26;
				end
			endcase
			target = events_sent + RandPerPhase;
			while (events_sent < target)
				run_burst();
		end
		wait_idle();

		$display("Sent %0d events over %0d register settings: %0d samples, %0d second ticks,",
			events_sent, NumPhases, op_counts[OP_SAMPLE], op_counts[OP_SECOND]);
		$display("%0d blink ticks, %0d starts, %0d to a missing port; %0d status beats, %0d cut-offs.",
			op_counts[OP_BLINK], op_counts[OP_START], bad_port_events, beats_checked,
			cutoffs_seen);
		if (fail_count == 0 && pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
